// ===== src/itp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, codes and helpers for the infix to postfix converter.
// ----------------------------------------------------------------------------
package itp_pkg;

  localparam int OPERAND_W = 32;

  localparam logic [2:0] TOK_OPERAND  = 3'd0;
  localparam logic [2:0] TOK_LPAREN   = 3'd1;
  localparam logic [2:0] TOK_RPAREN   = 3'd2;
  localparam logic [2:0] TOK_OPERATOR = 3'd3;
  localparam logic [2:0] TOK_END      = 3'd4;

  localparam logic [1:0] OUT_OPERAND  = 2'd0;
  localparam logic [1:0] OUT_OPERATOR = 2'd1;
  localparam logic [1:0] OUT_END      = 2'd2;
  localparam logic [1:0] OUT_ERROR    = 2'd3;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_RPAREN   = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;
  localparam logic [1:0] ERR_LPAREN   = 2'd3;

  localparam logic [2:0] OP_PLUS = 3'd1;
  localparam logic [2:0] OP_MOD  = 3'd4;

  localparam logic [3:0] LPAREN_ENTRY = 4'd8;

  typedef logic [3:0] entry_t;

  typedef struct packed {
    logic [2:0]           token_kind;
    logic [2:0]           op_code;
    logic [OPERAND_W-1:0] operand_value;
  } token_t;

  typedef struct packed {
    logic [1:0]           out_kind;
    logic [2:0]           out_op_code;
    logic [OPERAND_W-1:0] out_operand_value;
    logic [1:0]           error_code;
    logic                 last_of_run;
  } result_t;

  typedef struct packed {
    logic       latch;
    logic       push;
    logic       push_lparen;
    logic       pop;
    logic       emit;
    logic [1:0] emit_kind;
    logic [1:0] emit_err;
    logic       finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       stack_empty;
    logic       stack_full;
    logic       top_is_lparen;
    logic       yields;
    logic       pend_valid;
    logic       out_free;
  } dp_status_t;

  function automatic logic [1:0] prec_of(input logic [2:0] code);
    logic [1:0] p;
    if (code <= OP_PLUS) begin
      p = 2'd0;
    end else if (code <= OP_MOD) begin
      p = 2'd1;
    end else begin
      p = 2'd2;
    end
    return p;
  endfunction

endpackage

// ===== src/itp_stack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_stack
// Operator stack memory with entry count and a registered top-of-stack word.
// ----------------------------------------------------------------------------
module itp_stack #(
  parameter int STACK_DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  logic            pop,
  input  itp_pkg::entry_t push_entry,
  output itp_pkg::entry_t top,
  output logic            empty,
  output logic            full
);

  localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  itp_pkg::entry_t  mem [STACK_DEPTH];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] top_addr_next;

  always_comb begin
    count_next = count;
    if (push) begin
      count_next = count + CNT_W'(1);
    end else if (pop) begin
      count_next = count - CNT_W'(1);
    end
  end

  assign top_addr_next = count_next - CNT_W'(1);
  assign empty         = (count == '0);
  assign full          = (count == CNT_W'(STACK_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // keep top equal to the newest entry after every push or pop
  always_ff @(posedge clk) begin
    if (push) begin
      mem[count[IDX_W-1:0]] <= push_entry;
      top <= push_entry;
    end else begin
      top <= mem[top_addr_next[IDX_W-1:0]];
    end
  end

`ifndef SYNTH
  a_push_pop_excl: assert property (@(posedge clk) disable iff (rst)
    !(push && pop)) else $error("push and pop in the same cycle");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("push on a full stack");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("pop on an empty stack");
`endif

endmodule

// ===== src/itp_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_datapath
// Token hold register, operator stack, pending result and output register.
// ----------------------------------------------------------------------------
module itp_datapath #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  itp_pkg::token_t        token,
  input  itp_pkg::ctrl_cmd_t     cmd,
  input  logic                   result_stall,
  output itp_pkg::dp_status_t    status,
  output itp_pkg::result_t       result,
  output logic                   result_valid
);

  itp_pkg::token_t  tok;
  itp_pkg::result_t pend;
  itp_pkg::result_t out;
  itp_pkg::result_t fresh;
  itp_pkg::result_t moved;
  itp_pkg::entry_t  top;
  itp_pkg::entry_t  push_entry;
  logic             pend_valid;
  logic             out_valid;
  logic             out_free;
  logic             empty;
  logic             full;
  logic             move_out;

  assign push_entry = cmd.push_lparen ? itp_pkg::LPAREN_ENTRY : {1'b0, tok.op_code};

  itp_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk        (clk),
    .rst        (rst),
    .push       (cmd.push),
    .pop        (cmd.pop),
    .push_entry (push_entry),
    .top        (top),
    .empty      (empty),
    .full       (full)
  );

  always_comb begin
    fresh                   = '0;
    fresh.out_kind          = cmd.emit_kind;
    fresh.out_op_code       = (cmd.emit_kind == itp_pkg::OUT_OPERATOR) ? top[2:0] : 3'd0;
    fresh.out_operand_value = (cmd.emit_kind == itp_pkg::OUT_OPERAND) ?
                              tok.operand_value : '0;
    fresh.error_code        = (cmd.emit_kind == itp_pkg::OUT_ERROR) ?
                              cmd.emit_err : itp_pkg::ERR_NONE;
    fresh.last_of_run       = 1'b0;
  end

  always_comb begin
    moved             = pend;
    moved.last_of_run = cmd.finish;
  end

  assign out_free = !out_valid || !result_stall;
  assign move_out = (cmd.emit || cmd.finish) && pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (move_out) begin
        out_valid <= 1'b1;
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
      if (cmd.emit) begin
        pend_valid <= 1'b1;
      end else if (cmd.finish) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // hold the newest result back until it is known whether it ends the run
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      tok <= token;
    end
    if (cmd.emit) begin
      pend <= fresh;
    end
    if (move_out) begin
      out <= moved;
    end
  end

  assign status.kind          = tok.token_kind;
  assign status.stack_empty   = empty;
  assign status.stack_full    = full;
  assign status.top_is_lparen = (top == itp_pkg::LPAREN_ENTRY);
  assign status.yields        = itp_pkg::prec_of(tok.op_code) <= itp_pkg::prec_of(top[2:0]);
  assign status.pend_valid    = pend_valid;
  assign status.out_free      = out_free;

  assign result       = out;
  assign result_valid = out_valid;

`ifndef SYNTH
  a_finish_has_pend: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> pend_valid) else $error("finish without a pending word");
  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && pend_valid) |-> out_free) else $error("pending word overwritten");
  a_finish_marks_last: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (out_valid && out.last_of_run))
    else $error("run end not marked on output word");
`endif

endmodule

// ===== src/itp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_ctrl
// Controller: accepts tokens and steps the stack one entry per cycle, except while a result waits for output room.
// ----------------------------------------------------------------------------
module itp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                token_valid,
  output logic                token_stall,
  input  itp_pkg::dp_status_t status,
  output itp_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic {
    S_IDLE,
    S_WORK
  } state_t;

  state_t state;
  state_t state_next;
  logic   can_emit;

  assign can_emit    = !status.pend_valid || status.out_free;
  assign token_stall = !((state == S_IDLE) && can_emit);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.finish = status.pend_valid && status.out_free;
        if (token_valid && !token_stall) begin
          cmd.latch  = 1'b1;
          state_next = S_WORK;
        end
      end
      S_WORK: begin
        case (status.kind)
          itp_pkg::TOK_OPERAND: begin
            if (can_emit) begin
              cmd.emit      = 1'b1;
              cmd.emit_kind = itp_pkg::OUT_OPERAND;
              state_next    = S_IDLE;
            end
          end
          itp_pkg::TOK_LPAREN: begin
            if (!status.stack_full) begin
              cmd.push        = 1'b1;
              cmd.push_lparen = 1'b1;
              state_next      = S_IDLE;
            end else if (can_emit) begin
              cmd.emit      = 1'b1;
              cmd.emit_kind = itp_pkg::OUT_ERROR;
              cmd.emit_err  = itp_pkg::ERR_OVERFLOW;
              state_next    = S_IDLE;
            end
          end
          itp_pkg::TOK_RPAREN: begin
            if (status.stack_empty) begin
              if (can_emit) begin
                cmd.emit      = 1'b1;
                cmd.emit_kind = itp_pkg::OUT_ERROR;
                cmd.emit_err  = itp_pkg::ERR_RPAREN;
                state_next    = S_IDLE;
              end
            end else if (status.top_is_lparen) begin
              cmd.pop    = 1'b1;
              state_next = S_IDLE;
            end else if (can_emit) begin
              cmd.emit      = 1'b1;
              cmd.emit_kind = itp_pkg::OUT_OPERATOR;
              cmd.pop       = 1'b1;
            end
          end
          itp_pkg::TOK_OPERATOR: begin
            if (!status.stack_empty && !status.top_is_lparen && status.yields) begin
              if (can_emit) begin
                cmd.emit      = 1'b1;
                cmd.emit_kind = itp_pkg::OUT_OPERATOR;
                cmd.pop       = 1'b1;
              end
            end else if (!status.stack_full) begin
              cmd.push   = 1'b1;
              state_next = S_IDLE;
            end else if (can_emit) begin
              cmd.emit      = 1'b1;
              cmd.emit_kind = itp_pkg::OUT_ERROR;
              cmd.emit_err  = itp_pkg::ERR_OVERFLOW;
              state_next    = S_IDLE;
            end
          end
          itp_pkg::TOK_END: begin
            if (can_emit) begin
              cmd.emit = 1'b1;
              if (status.stack_empty) begin
                cmd.emit_kind = itp_pkg::OUT_END;
                state_next    = S_IDLE;
              end else if (status.top_is_lparen) begin
                cmd.emit_kind = itp_pkg::OUT_ERROR;
                cmd.emit_err  = itp_pkg::ERR_LPAREN;
                cmd.pop       = 1'b1;
              end else begin
                cmd.emit_kind = itp_pkg::OUT_OPERATOR;
                cmd.pop       = 1'b1;
              end
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/infix_to_postfix_converter.sv =====
`timescale 1ns / 1ps
// Operation: a token is latched into the hold register while idle; each stack push, pop or result
//   is then a step of its own, and the last result of a token moves from pending to the output register.
// Throughput: a new token is taken only once the previous one is done; right parens, operators and
//   end tokens add a step for each entry popped with a result, and an output stall holds them.
// Reset: clears the controller, stack count, pending and output valid; stack contents are not cleared.
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter from classified infix tokens to postfix words.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             token_valid,
  output logic             token_stall,
  input  itp_pkg::token_t  token,
  output logic             result_valid,
  input  logic             result_stall,
  output itp_pkg::result_t result
);

  itp_pkg::ctrl_cmd_t  cmd;
  itp_pkg::dp_status_t status;

  itp_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .status      (status),
    .cmd         (cmd)
  );

  itp_datapath #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .token        (token),
    .cmd          (cmd),
    .result_stall (result_stall),
    .status       (status),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule
